FILE: rtl/core/binary_morphology_filter_assert.svh
// assertion macros shared by the morphology filter rtl
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef BINARY_MORPHOLOGY_FILTER_ASSERT_SVH
`define BINARY_MORPHOLOGY_FILTER_ASSERT_SVH

// same-cycle implication
`define BMF_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BMF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/bmf_pkg.sv
// shared types, constants and helpers of the binary morphology filter
// no dependencies
package bmf_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_STAGES = 4;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned CW        = 11;  // row and column cursors
  localparam int unsigned APB_AW    = 5;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned REG_IDX_W = 3;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [CW-1:0]    coord_t;

  // operation field
  localparam logic OP_PUSH = 1'b0;

  // morph_mode codes
  localparam logic [1:0] MODE_ERODE  = 2'd0;
  localparam logic [1:0] MODE_DILATE = 2'd1;
  localparam logic [1:0] MODE_OPEN   = 2'd2;
  localparam logic [1:0] MODE_CLOSE  = 2'd3;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MODE   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LARGE  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BORDER = 3'd4;

  // register reset values
  localparam coord_t     RST_WIDTH  = 11'd640;
  localparam coord_t     RST_HEIGHT = 11'd480;
  localparam logic [1:0] RST_MODE   = MODE_ERODE;
  localparam logic       RST_LARGE  = 1'b0;
  localparam pix_t       RST_BORDER = 8'd0;

  // frame geometry and border seen by every stage
  typedef struct packed {
    coord_t wm1;     // last column index
    coord_t hm1;     // last row index
    pix_t   border;
    logic   clear;   // geometry or mode write, restart cursors
  } cfg_t;

  // one pixel beat between stages
  typedef struct packed {
    logic has;
    pix_t pix;
    logic last;
  } beat_t;

  function automatic pix_t combine3(pix_t a, pix_t b, pix_t c, logic use_and);
    return use_and ? (a & b & c) : (a | b | c);
  endfunction

  function automatic logic [2:0] stage_count(logic [1:0] mode, logic large_size);
    logic [2:0] n;
    n = large_size ? 3'd2 : 3'd1;
    return (mode == MODE_OPEN || mode == MODE_CLOSE) ? (n << 1) : n;
  endfunction

  function automatic logic stage_and(logic [1:0] mode, logic large_size, logic [2:0] idx);
    logic [2:0] n;
    logic       r;
    n = large_size ? 3'd2 : 3'd1;
    case (mode)
      MODE_ERODE:  r = 1'b1;
      MODE_DILATE: r = 1'b0;
      MODE_OPEN:   r = (idx < n);
      default:     r = (idx >= n);  // closing
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/binary_morphology_filter.sv
// top level of the streaming 3x3 / 5x5 binary morphology filter
// depends on bmf_pkg, bmf_regs, bmf_stage and binary_morphology_filter_assert.svh
//
// Pixels enter in raster order at one beat per clock and leave at one beat per
// clock unless out_ready_i stalls them: each beat goes from the input register
// through all stages combinationally into the result register, so throughput is
// one pixel per clock when not stalled, set by the combinational stage chain and
// each stage's line store (one write and two registered reads per cycle). Each
// stage is a vertical 3-tap pass over two row buffers followed by a horizontal
// 3-tap pass, AND for erode and OR for dilate; opening and closing chain both,
// and large_size doubles every operation (5x5). A stage releases pixel p once
// the vertical value right of it exists; after the last pixel of a frame, drain
// beats (operation = 1) or the next frame's pixels push the rest out, and the
// final pixel carries end_of_frame. Neighbors outside the frame read
// border_value. Writing width, height, mode or large_size restarts the frame;
// write them only while the filter is idle. The line stores need no clearing
// after reset, so beats are taken at once.
`include "binary_morphology_filter_assert.svh"

module binary_morphology_filter #(
  parameter int unsigned MAX_WIDTH  = bmf_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_STAGES = bmf_pkg::DEF_MAX_STAGES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // pixel input channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        operation_i,
  input  logic [bmf_pkg::PIX_W-1:0]   pixel_in_i,
  // pixel output channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bmf_pkg::PIX_W-1:0]   pixel_out_o,
  output logic                        end_of_frame_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bmf_pkg::APB_AW-1:0]  paddr,
  input  logic [bmf_pkg::APB_DW-1:0]  pwdata,
  output logic [bmf_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import bmf_pkg::*;

  cfg_t       cfg;
  logic [1:0] mode;
  logic       large_size;
  logic [2:0] stg_cnt;

  // input register
  logic itm_valid_q;
  logic itm_op_q;
  pix_t itm_pix_q;

  // result register
  logic res_valid_q;
  pix_t res_pix_q;
  logic res_eof_q;

  logic  res_free, step;
  beat_t chain [MAX_STAGES+1];
  beat_t fin_beat;

  bmf_regs #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .cfg_o        (cfg),
    .morph_mode_o (mode),
    .large_size_o (large_size)
  );

  // the held beat moves on when the result register is empty or being taken
  assign res_free   = !res_valid_q || out_ready_i;
  assign step       = itm_valid_q && res_free;
  assign in_ready_o = !itm_valid_q || res_free;

  assign stg_cnt = stage_count(mode, large_size);

  assign chain[0].has  = step && (itm_op_q == OP_PUSH);
  assign chain[0].pix  = itm_pix_q;
  assign chain[0].last = 1'b0;

  // stages past the mode's count pass beats through untouched
  for (genvar s = 0; s < MAX_STAGES; s++) begin : g_stage
    logic stg_en;
    logic stg_and;
    assign stg_en  = (3'(s) < stg_cnt);
    assign stg_and = stage_and(mode, large_size, 3'(s));

    bmf_stage #(
      .MAX_WIDTH (MAX_WIDTH)
    ) u_stage (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tick_i    (step && stg_en),
      .use_and_i (stg_and),
      .cfg_i     (cfg),
      .beat_i    (chain[s]),
      .beat_o    (chain[s+1])
    );
  end

  assign fin_beat = chain[MAX_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      itm_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        itm_valid_q <= 1'b1;
      end else if (step) begin
        itm_valid_q <= 1'b0;
      end
      if (step) begin
        res_valid_q <= fin_beat.has;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      itm_op_q  <= operation_i;
      itm_pix_q <= pixel_in_i;
    end
    if (step && fin_beat.has) begin
      res_pix_q <= fin_beat.pix;
      res_eof_q <= fin_beat.last;
    end
  end

  assign out_valid_o    = res_valid_q;
  assign pixel_out_o    = res_pix_q;
  assign end_of_frame_o = res_eof_q;

  `BMF_ASSERT_IMPL(a_no_step_on_stall, res_valid_q && !out_ready_i, !step, "beat advanced into a stalled result")
  `BMF_ASSERT_NEXT(a_empty_step, step && !fin_beat.has, !res_valid_q, "result shown for a beat with no pixel")
  `BMF_ASSERT_NEXT(a_accept_loads, in_valid_i && in_ready_o, itm_valid_q, "accepted beat not held")

endmodule

FILE: rtl/core/bmf_stage.sv
// one separable 3x3 morphology stage: line store, vertical pass, horizontal pass
// depends on bmf_pkg and binary_morphology_filter_assert.svh
`include "binary_morphology_filter_assert.svh"

module bmf_stage #(
  parameter int unsigned MAX_WIDTH = bmf_pkg::DEF_MAX_WIDTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          tick_i,
  input  logic          use_and_i,
  input  bmf_pkg::cfg_t  cfg_i,
  input  bmf_pkg::beat_t beat_i,
  output bmf_pkg::beat_t beat_o
);
  import bmf_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  typedef logic [AW-1:0] addr_t;
  typedef logic [2*PIX_W-1:0] pair_t;  // {row above, current row}

  coord_t ir_q, ic_q, vr_q, vc_q, hr_q, hc_q;
  coord_t ir_d, ic_d, vr_d, vc_d, hr_d, hc_d;
  logic [1:0] diff_q, diff_d;   // vertical values not yet consumed
  logic       ahead_q, ahead_d;
  pix_t tap0_q, tap1_q, tap2_q;
  pix_t tap0_d, tap1_d, tap2_d;

  pair_t mem_q [MAX_WIDTH];
  pair_t rdv_q, rdi_q, wdat_q;
  logic  fwdv_q, fwdi_q;
  pair_t rd_v, rd_i, wdat;
  logic  we;
  addr_t waddr;

  logic vlast_row, vok, vwrap, iwrap, lastpos, fire, wide;
  logic [1:0] diff_mid;
  pix_t below, above, vval, t0, t1, t2, left, center, right, yval;

  assign rd_v = fwdv_q ? wdat_q : rdv_q;
  assign rd_i = fwdi_q ? wdat_q : rdi_q;

  // vertical pass
  always_comb begin
    vlast_row = (vr_q >= cfg_i.hm1);
    if (vlast_row) begin
      vok   = ahead_q || (ir_q > vr_q) || ((ir_q == vr_q) && (ic_q > vc_q));
      below = cfg_i.border;
    end else begin
      vok   = beat_i.has && !ahead_q && (ir_q == vr_q + coord_t'(1)) && (ic_q == vc_q);
      below = beat_i.pix;
    end
    above = (vr_q != '0) ? rd_v[2*PIX_W-1:PIX_W] : cfg_i.border;
    vval  = combine3(above, rd_v[PIX_W-1:0], below, use_and_i);
    vwrap = vok && (vc_q >= cfg_i.wm1) && (vr_q >= cfg_i.hm1);
    iwrap = beat_i.has && (ic_q >= cfg_i.wm1) && (ir_q >= cfg_i.hm1);
  end

  // horizontal pass over the last three vertical values
  always_comb begin
    t0 = vok ? vval   : tap0_q;
    t1 = vok ? tap0_q : tap1_q;
    t2 = vok ? tap1_q : tap2_q;
    diff_mid = diff_q + 2'(vok);
    lastpos  = (hr_q >= cfg_i.hm1) && (hc_q >= cfg_i.wm1);
    fire     = lastpos ? (diff_mid != 2'd0) : (diff_mid >= 2'd2);
    wide     = (diff_mid == 2'd2);
    center   = wide ? t1 : t0;
    left     = (hc_q != '0) ? (wide ? t2 : t1) : cfg_i.border;
    right    = (hc_q < cfg_i.wm1) ? t0 : cfg_i.border;
    yval     = combine3(left, center, right, use_and_i);
  end

  always_comb begin
    if (tick_i) begin
      beat_o.has  = fire;
      beat_o.pix  = yval;
      beat_o.last = lastpos;
    end else begin
      beat_o = beat_i;  // stage not in the chain for this mode, or the chain is not stepping
    end
  end

  // line store write: row above takes the old current row
  assign we    = tick_i && beat_i.has;
  assign waddr = addr_t'(ic_q);
  assign wdat  = {rd_i[PIX_W-1:0], beat_i.pix};

  always_comb begin
    ir_d = ir_q; ic_d = ic_q; vr_d = vr_q; vc_d = vc_q; hr_d = hr_q; hc_d = hc_q;
    diff_d = diff_q; ahead_d = ahead_q;
    tap0_d = tap0_q; tap1_d = tap1_q; tap2_d = tap2_q;
    if (cfg_i.clear) begin
      ir_d = '0; ic_d = '0; vr_d = '0; vc_d = '0; hr_d = '0; hc_d = '0;
      diff_d = '0; ahead_d = 1'b0;
    end else if (tick_i) begin
      tap0_d = t0; tap1_d = t1; tap2_d = t2;
      diff_d = diff_mid - 2'(fire);
      if (vok) begin
        if (vc_q >= cfg_i.wm1) begin
          vc_d = '0;
          vr_d = (vr_q >= cfg_i.hm1) ? '0 : vr_q + coord_t'(1);
        end else begin
          vc_d = vc_q + coord_t'(1);
        end
      end
      if (beat_i.has) begin
        if (ic_q >= cfg_i.wm1) begin
          ic_d = '0;
          ir_d = (ir_q >= cfg_i.hm1) ? '0 : ir_q + coord_t'(1);
        end else begin
          ic_d = ic_q + coord_t'(1);
        end
      end
      if (iwrap) begin
        ahead_d = 1'b1;
      end else if (vwrap) begin
        ahead_d = 1'b0;
      end
      if (fire) begin
        if (hc_q >= cfg_i.wm1) begin
          hc_d = '0;
          hr_d = (hr_q >= cfg_i.hm1) ? '0 : hr_q + coord_t'(1);
        end else begin
          hc_d = hc_q + coord_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ir_q <= '0; ic_q <= '0; vr_q <= '0; vc_q <= '0; hr_q <= '0; hc_q <= '0;
      diff_q <= '0; ahead_q <= 1'b0;
      fwdv_q <= 1'b0; fwdi_q <= 1'b0;
    end else begin
      ir_q <= ir_d; ic_q <= ic_d; vr_q <= vr_d; vc_q <= vc_d; hr_q <= hr_d; hc_q <= hc_d;
      diff_q <= diff_d; ahead_q <= ahead_d;
      fwdv_q <= we && (waddr == addr_t'(vc_d));
      fwdi_q <= we && (waddr == addr_t'(ic_d));
    end
  end

  // window taps and line store, read ahead at the next cursors
  always_ff @(posedge clk_i) begin
    tap0_q <= tap0_d;
    tap1_q <= tap1_d;
    tap2_q <= tap2_d;
    if (we) begin
      mem_q[waddr] <= wdat;
    end
    rdv_q  <= mem_q[addr_t'(vc_d)];
    rdi_q  <= mem_q[addr_t'(ic_d)];
    wdat_q <= wdat;
  end

  `BMF_ASSERT_NEXT(a_clear_restarts, cfg_i.clear, (ir_q == '0) && (ic_q == '0) && (vr_q == '0) && (vc_q == '0) && (diff_q == '0) && !ahead_q, "stage cursors not cleared")
  `BMF_ASSERT_IMPL(a_vert_same_col, tick_i && vok && !vlast_row, ic_q == vc_q, "vertical pass off the input column")
  `BMF_ASSERT_IMPL(a_window_depth, 1'b1, diff_q != 2'd3, "horizontal pass fell behind the window")
  `BMF_ASSERT_NEXT(a_hold_idle, !tick_i && !cfg_i.clear, $stable(ic_q) && $stable(vc_q) && $stable(hc_q) && $stable(diff_q), "stage moved without a tick")

endmodule

FILE: rtl/core/bmf_regs.sv
// apb configuration registers and derived frame geometry
// depends on bmf_pkg
module bmf_regs #(
  parameter int unsigned MAX_WIDTH = bmf_pkg::DEF_MAX_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bmf_pkg::APB_AW-1:0]   paddr,
  input  logic [bmf_pkg::APB_DW-1:0]   pwdata,
  output logic [bmf_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output bmf_pkg::cfg_t                cfg_o,
  output logic [1:0]                   morph_mode_o,
  output logic                         large_size_o
);
  import bmf_pkg::*;

  localparam int unsigned WCAP    = (MAX_WIDTH > (2**CW - 1)) ? (2**CW - 1) : MAX_WIDTH;
  localparam coord_t      WCAP_M1 = coord_t'(WCAP - 1);

  coord_t     width_q, height_q;
  logic [1:0] mode_q;
  logic       large_q;
  pix_t       border_q;
  logic       clear_q, clear_d;
  logic       wr;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[APB_AW-1:2];

  always_comb begin
    clear_d = 1'b0;
    if (wr) begin
      unique case (idx)
        REG_WIDTH, REG_HEIGHT, REG_MODE, REG_LARGE: clear_d = 1'b1;
        default: clear_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_WIDTH;
      height_q <= RST_HEIGHT;
      mode_q   <= RST_MODE;
      large_q  <= RST_LARGE;
      border_q <= RST_BORDER;
      clear_q  <= 1'b0;
    end else begin
      clear_q <= clear_d;
      if (wr) begin
        unique case (idx)
          REG_WIDTH:  width_q  <= pwdata[CW-1:0];
          REG_HEIGHT: height_q <= pwdata[CW-1:0];
          REG_MODE:   mode_q   <= pwdata[1:0];
          REG_LARGE:  large_q  <= pwdata[0];
          REG_BORDER: border_q <= pwdata[PIX_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (idx)
      REG_WIDTH:  prdata = APB_DW'(width_q);
      REG_HEIGHT: prdata = APB_DW'(height_q);
      REG_MODE:   prdata = APB_DW'(mode_q);
      REG_LARGE:  prdata = APB_DW'(large_q);
      REG_BORDER: prdata = APB_DW'(border_q);
      default:    prdata = '0;
    endcase
  end

  // zero width acts as one, widths past the line store saturate
  always_comb begin
    if (width_q == '0) begin
      cfg_o.wm1 = '0;
    end else if (width_q > coord_t'(WCAP)) begin
      cfg_o.wm1 = WCAP_M1;
    end else begin
      cfg_o.wm1 = width_q - coord_t'(1);
    end
    cfg_o.hm1    = (height_q == '0) ? '0 : height_q - coord_t'(1);
    cfg_o.border = border_q;
    cfg_o.clear  = clear_d;
  end

  assign morph_mode_o = mode_q;
  assign large_size_o = large_q;

  // clear_q only marks the cycle after a restart, used by nothing but readers of timing
  logic unused_clear;
  assign unused_clear = clear_q;

endmodule

FILE: verif/binary_morphology_filter_tb.sv
// self-checking testbench for binary_morphology_filter: random frames in every mode and size
// depends on bmf_pkg and the filter rtl; carries its own cycle-level model of the stage chain
module binary_morphology_filter_tb;
  import bmf_pkg::*;

  localparam int unsigned MW = DEF_MAX_WIDTH;
  localparam int unsigned MS = DEF_MAX_STAGES;

  localparam logic OP_DRAIN = ~OP_PUSH;

  // pixel content styles for a frame
  localparam int unsigned STYLE_NOISE  = 0;
  localparam int unsigned STYLE_HOLES  = 1;  // mostly set, a few random pixels
  localparam int unsigned STYLE_SPECKS = 2;  // mostly clear, a few random pixels
  localparam int unsigned STYLE_BINARY = 3;  // only 00 and ff
  localparam int unsigned STYLE_CORNER = 4;  // fixed pattern of extreme values

  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned RANDOM_PUSHES = 2000;

  // one input beat and one result beat
  typedef struct packed {
    logic op;
    pix_t pix;
  } feed_t;

  typedef struct packed {
    pix_t pix;
    logic eof;
  } filtered_t;

  // cursors of one stage, same meaning as the stage's position counters
  typedef struct packed {
    logic [31:0] ir, ic, vr, vc, hr, hc, vcount, hcount;
    logic        ahead;
  } cursor_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic              operation_i    = OP_PUSH;
  logic [PIX_W-1:0]  pixel_in_i     = '0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic [PIX_W-1:0]  pixel_out_o;
  logic              end_of_frame_o;
  logic              psel           = 1'b0;
  logic              penable        = 1'b0;
  logic              pwrite         = 1'b0;
  logic [APB_AW-1:0] paddr          = '0;
  logic [APB_DW-1:0] pwdata         = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  binary_morphology_filter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .pixel_in_i    (pixel_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_out_o   (pixel_out_o),
    .end_of_frame_o(end_of_frame_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // filter model: register mirror plus per-stage line stores, windows, cursors
  // ---------------------------------------------------------------------------
  coord_t     cfg_width  = RST_WIDTH;
  coord_t     cfg_height = RST_HEIGHT;
  logic [1:0] cfg_mode   = RST_MODE;
  logic       cfg_large  = RST_LARGE;
  pix_t       cfg_border = RST_BORDER;

  pix_t    row_store [MS*2*MW];  // per stage: row above, then current row
  pix_t    vwin      [MS*4];     // per stage: last four vertical results
  cursor_t cursors   [MS];

  filtered_t want_pixels [$];   // results still to come out, oldest first
  feed_t     feed_beats  [$];   // beats waiting for the driver

  int unsigned fail_count = 0;
  int unsigned pushed     = 0;

  function automatic pix_t merge3(pix_t a, pix_t b, pix_t c, bit use_and);
    return use_and ? (a & b & c) : (a | b | c);
  endfunction

  // zero acts as one, anything past the line store saturates
  function automatic int unsigned frame_cols(coord_t v);
    if (v == 0) return 1;
    if (v > MW) return MW;
    return v;
  endfunction

  function automatic int unsigned frame_rows(coord_t v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic int unsigned chain_len(logic [1:0] mode, logic big);
    int unsigned n;
    n = big ? 2 : 1;
    if (mode == MODE_OPEN || mode == MODE_CLOSE) n = 2 * n;
    return (n > MS) ? MS : n;
  endfunction

  task automatic clear_cursors();
    for (int i = 0; i < MS; i++) cursors[i] = '0;
  endtask

  // one clock of one stage: vertical pass, store of the incoming pixel, horizontal pass
  task automatic stage_clock(input int unsigned s, inout bit has, inout pix_t x,
                             input int unsigned w, input int unsigned h, input pix_t b,
                             input bit use_and, output bit eof);
    cursor_t     c;
    int unsigned top, cur, win, vcol, icol;
    logic [31:0] diff;
    pix_t        below, above, left, right;
    bit          vok, at_end;
    c     = cursors[s];
    top   = s * 2 * MW;
    cur   = top + MW;
    win   = s * 4;
    below = b;
    vcol  = c.vc % MW;
    eof   = 1'b0;

    // last row needs no pixel below, otherwise wait for the pixel right under it
    if (c.vr >= h - 1) begin
      vok = c.ahead || c.ir > c.vr || (c.ir == c.vr && c.ic > c.vc);
    end else begin
      vok   = has && !c.ahead && c.ir == c.vr + 1 && c.ic == c.vc;
      below = x;
    end
    if (vok) begin
      above = (c.vr > 0) ? row_store[top + vcol] : b;
      vwin[win + (c.vcount & 3)] = merge3(above, row_store[cur + vcol], below, use_and);
      c.vcount++;
      c.vc++;
      if (c.vc >= w) begin
        c.vc = 0;
        c.vr++;
        if (c.vr >= h) begin
          c.vr    = 0;
          c.ahead = 1'b0;
        end
      end
    end

    if (has) begin
      icol = c.ic % MW;
      row_store[top + icol] = row_store[cur + icol];
      row_store[cur + icol] = x;
      c.ic++;
      if (c.ic >= w) begin
        c.ic = 0;
        c.ir++;
        if (c.ir >= h) begin
          c.ir    = 0;
          c.ahead = 1'b1;
        end
      end
    end

    // the frame's final pixel only needs its own vertical value
    at_end = (c.hr >= h - 1) && (c.hc >= w - 1);
    diff   = c.vcount - c.hcount;
    has    = 1'b0;
    x      = '0;
    if (diff >= (at_end ? 1 : 2) && diff <= 4) begin
      left  = (c.hc > 0) ? vwin[win + ((c.hcount - 1) & 3)] : b;
      right = (c.hc < w - 1) ? vwin[win + ((c.hcount + 1) & 3)] : b;
      x     = merge3(left, vwin[win + (c.hcount & 3)], right, use_and);
      eof   = at_end;
      has   = 1'b1;
      c.hcount++;
      c.hc++;
      if (c.hc >= w) begin
        c.hc = 0;
        c.hr++;
        if (c.hr >= h) c.hr = 0;
      end
    end
    cursors[s] = c;
  endtask

  // run an accepted beat through the whole chain, queue the pixel it releases
  task automatic filter_beat(input logic op, input pix_t pin);
    int unsigned w, h, n, cnt, s;
    bit          has, use_and, eof;
    pix_t        x;
    w   = frame_cols(cfg_width);
    h   = frame_rows(cfg_height);
    n   = cfg_large ? 2 : 1;
    cnt = chain_len(cfg_mode, cfg_large);
    has = (op == OP_PUSH);
    x   = pin;
    eof = 1'b0;
    for (s = 0; s < cnt; s++) begin
      case (cfg_mode)
        MODE_ERODE:  use_and = 1'b1;
        MODE_DILATE: use_and = 1'b0;
        MODE_OPEN:   use_and = (s < n);
        default:     use_and = (s >= n);  // closing: dilate first
      endcase
      stage_clock(s, has, x, w, h, cfg_border, use_and, eof);
    end
    if (has) want_pixels.push_back('{pix: x, eof: eof});
  endtask

  // ---------------------------------------------------------------------------
  // driver: bursts of beats from feed_beats with random gaps in between
  // ---------------------------------------------------------------------------
  int unsigned gap_left   = 0;
  int unsigned burst_left = 1;
  feed_t       next_beat;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) filter_beat(operation_i, pixel_in_i);
      // payload only moves once the current beat is gone
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (feed_beats.size() != 0) begin
          next_beat   = feed_beats.pop_front();
          in_valid_i  <= 1'b1;
          operation_i <= next_beat.op;
          pixel_in_i  <= next_beat.pix;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 48);
            // a third of the bursts follow with no gap at all
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: receiver stall pattern and in-order compare against the model
  // ---------------------------------------------------------------------------
  logic [15:0] rx_cycle = '0;
  logic [1:0]  rx_mode  = '0;
  filtered_t   head_beat;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      rx_cycle <= rx_cycle + 1;
      // new stall flavor whenever the low seven bits of rx_cycle are zero
      if (rx_cycle[6:0] == 0) rx_mode <= $urandom_range(0, 3);
      case (rx_mode)
        2'd0:    out_ready_i <= 1'b1;
        2'd1:    out_ready_i <= $urandom_range(0, 1);
        2'd2:    out_ready_i <= (rx_cycle[1:0] == 0);
        default: out_ready_i <= ($urandom_range(0, 9) != 0);
      endcase

      if (out_valid_o && out_ready_i) begin
        if (want_pixels.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected beat, pixel %02h eof %0b",
                     $time, pixel_out_o, end_of_frame_o);
          fail_count++;
        end else begin
          head_beat = want_pixels.pop_front();
          if (head_beat.pix !== pixel_out_o || head_beat.eof !== end_of_frame_o) begin
            if (fail_count < 10)
              $display("%0t: mismatch, expected pixel %02h eof %0b, got pixel %02h eof %0b",
                       $time, head_beat.pix, head_beat.eof, pixel_out_o, end_of_frame_o);
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog: no beat on either channel and no register write for too long
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("binary_morphology_filter verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // setup then access cycle; the model register changes at the write edge
  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_WIDTH: begin
        cfg_width = val[CW-1:0];
        clear_cursors();
      end
      REG_HEIGHT: begin
        cfg_height = val[CW-1:0];
        clear_cursors();
      end
      REG_MODE: begin
        cfg_mode = val[1:0];
        clear_cursors();
      end
      REG_LARGE: begin
        cfg_large = val[0];
        clear_cursors();
      end
      REG_BORDER: cfg_border = val[PIX_W-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // idle means nothing queued, nothing on the wire and no result outstanding
  task automatic wait_drained();
    do @(negedge clk_i);
    while (feed_beats.size() != 0 || in_valid_i || want_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // sometimes fill the unused upper bits of a register write with noise
  function automatic logic [31:0] junk_above(int unsigned bits);
    return ($urandom_range(0, 3) == 0) ? (32'($urandom()) << bits) : 32'd0;
  endfunction

  function automatic pix_t pick_pixel(int unsigned style, int unsigned idx);
    case (style)
      STYLE_NOISE:  return pix_t'($urandom());
      STYLE_HOLES:  return ($urandom_range(0, 7) == 0) ? pix_t'($urandom()) : 8'hFF;
      STYLE_SPECKS: return ($urandom_range(0, 7) == 0) ? pix_t'($urandom()) : 8'h00;
      STYLE_BINARY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: begin
        case (idx % 6)
          0:       return 8'hFF;
          1:       return 8'h00;
          2:       return 8'h80;
          3:       return 8'h01;
          4:       return 8'hAA;
          default: return 8'h55;
        endcase
      end
    endcase
  endfunction

  // drain beats carry a random pixel that must be ignored
  task automatic queue_drains(int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      feed_beats.push_back('{op: OP_DRAIN, pix: pix_t'($urandom())});
  endtask

  // enough drain beats to empty every stage of the current chain
  function automatic int unsigned flush_len();
    return chain_len(cfg_mode, cfg_large) * (frame_cols(cfg_width) + 2) + 4;
  endfunction

  task automatic queue_frame(int unsigned style);
    int unsigned total;
    total = frame_cols(cfg_width) * frame_rows(cfg_height);
    for (int unsigned i = 0; i < total; i++) begin
      // a stray drain in mid frame must change nothing
      if ($urandom_range(0, 11) == 0) queue_drains(1);
      feed_beats.push_back('{op: OP_PUSH, pix: pick_pixel(style, i)});
      pushed++;
    end
  endtask

  // reprogram everything while idle, then send a few frames and flush
  task automatic run_phase(coord_t w, coord_t h, logic [1:0] mode, logic big,
                           pix_t border, int unsigned frames, int unsigned style);
    wait_drained();
    reg_write(REG_WIDTH,  junk_above(CW) | 32'(w));
    reg_write(REG_HEIGHT, junk_above(CW) | 32'(h));
    reg_write(REG_MODE,   junk_above(2) | 32'(mode));
    reg_write(REG_LARGE,  junk_above(1) | 32'(big));
    reg_write(REG_BORDER, junk_above(PIX_W) | 32'(border));
    @(negedge clk_i);
    for (int unsigned f = 0; f < frames; f++) begin
      if (f != 0) begin
        case ($urandom_range(0, 2))
          0: ;  // back to back: the next frame pushes out the held tail
          1: queue_drains($urandom_range(0, frame_cols(cfg_width)));
          default: begin
            // full flush, then a border change alone keeps the frame geometry
            queue_drains(flush_len());
            wait_drained();
            reg_write(REG_BORDER, junk_above(PIX_W) | 32'($urandom_range(0, 255)));
            @(negedge clk_i);
          end
        endcase
      end
      queue_frame(style);
    end
    queue_drains(flush_len());
  endtask

  function automatic coord_t pick_extent();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(1, 3);
      8:       return $urandom_range(13, 40);
      9:       return $urandom_range(41, 100);
      default: return $urandom_range(2, 12);
    endcase
  endfunction

  function automatic pix_t pick_border();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return pix_t'($urandom());
    endcase
  endfunction

  initial begin
    for (int i = 0; i < MS * 2 * MW; i++) row_store[i] = '0;
    for (int i = 0; i < MS * 4; i++) vwin[i] = '0;
    clear_cursors();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // tiny erode frame of extreme values against an all-ones border
    run_phase(11'd4, 11'd3, MODE_ERODE, 1'b0, 8'hFF, 1, STYLE_CORNER);

    // every mode at both sizes
    for (int m = 0; m < 4; m++) begin
      run_phase(11'd5, 11'd4, m[1:0], 1'b0, pick_border(), 2, STYLE_BINARY);
      run_phase(11'd7, 11'd6, m[1:0], 1'b1, pick_border(), 2, STYLE_NOISE);
    end

    // degenerate and out-of-range geometry
    run_phase(11'd0,    11'd3,    MODE_OPEN,   1'b1, 8'h00, 2, STYLE_NOISE);
    run_phase(11'd5,    11'd0,    MODE_CLOSE,  1'b0, 8'hFF, 2, STYLE_NOISE);
    run_phase(11'd1,    11'd1,    MODE_DILATE, 1'b1, 8'h5A, 3, STYLE_NOISE);
    run_phase(11'd2,    11'd1,    MODE_CLOSE,  1'b1, 8'hA5, 2, STYLE_NOISE);
    run_phase(11'd1,    11'd2047, MODE_OPEN,   1'b0, 8'h00, 1, STYLE_HOLES);
    run_phase(11'd2047, 11'd1,    MODE_ERODE,  1'b1, 8'hFF, 1, STYLE_HOLES);
    run_phase(11'd1024, 11'd2,    MODE_CLOSE,  1'b1, 8'h00, 1, STYLE_SPECKS);

    // random geometry, modes and content, mostly small frames
    pushed = 0;
    while (pushed < RANDOM_PUSHES) begin
      run_phase(pick_extent(), pick_extent(), 2'($urandom_range(0, 3)),
                1'($urandom_range(0, 1)), pick_border(), $urandom_range(1, 3),
                $urandom_range(STYLE_NOISE, STYLE_BINARY));
    end

    wait_drained();
    if (fail_count == 0 && want_pixels.size() == 0) begin
      $display("binary_morphology_filter verification clean");
    end else begin
      $display("binary_morphology_filter verification failed");
    end
    $finish;
  end

endmodule
